// ----- sv/mfd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types and constants for the multi-format frame delineator.
// ----------------------------------------------------------------------------
package mfd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned IndexW = 17;
  localparam int unsigned KindW  = 3;
  localparam int unsigned PreW   = 3;

  localparam logic [IndexW-1:0] CountMax = {IndexW{1'b1}};

  // Special byte values
  localparam logic [ByteW-1:0] ByteFlag     = 8'h7E;
  localparam logic [ByteW-1:0] BytePreamble = 8'hA5;
  localparam logic [ByteW-1:0] ByteFifteen  = 8'h0A;
  localparam logic [3:0]       DualHighMask = 4'hF;

  // Frame positions and length offsets
  localparam logic [IndexW-1:0] IdxSecond   = 17'd1;
  localparam logic [IndexW-1:0] IdxLenByte  = 17'd4;
  localparam logic [IndexW-1:0] IdxAreaLast = 17'd7;
  localparam logic [IndexW-1:0] IdxDualHigh = 17'd11;
  localparam logic [IndexW-1:0] IdxDualLow  = 17'd12;
  localparam logic [IndexW-1:0] IdxBqLow    = 17'd12;
  localparam logic [IndexW-1:0] IdxBqHigh   = 17'd13;
  localparam logic [IndexW-1:0] LenFifteen  = 17'd15;
  localparam logic [IndexW-1:0] LenShortAdd = 17'd5;
  localparam logic [IndexW-1:0] LenHdrAdd   = 17'd17;

  // Preamble run limits
  localparam logic [PreW-1:0] PreRunFull = 3'd6;
  localparam logic [PreW-1:0] PreRunMin  = 3'd5;

  // Frame class codes
  localparam logic [KindW-1:0] KindStart   = 3'd0;
  localparam logic [KindW-1:0] KindLength  = 3'd1;
  localparam logic [KindW-1:0] KindFifteen = 3'd2;
  localparam logic [KindW-1:0] KindDual    = 3'd3;
  localparam logic [KindW-1:0] KindBq      = 3'd4;
  localparam logic [KindW-1:0] KindArea    = 3'd5;

  typedef enum logic [7:0] {
    MODE_IDLE    = 8'b0000_0001,
    MODE_START   = 8'b0000_0010,
    MODE_LEN     = 8'b0000_0100,
    MODE_FIFTEEN = 8'b0000_1000,
    MODE_PRE     = 8'b0001_0000,
    MODE_BQ      = 8'b0010_0000,
    MODE_AREA    = 8'b0100_0000,
    MODE_DUAL    = 8'b1000_0000
  } mode_t;

endpackage : mfd_pkg
`default_nettype wire

// ----- sv/multi_format_frame_delineator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multi_format_frame_delineator
// Sorts received serial bytes into 7E, length, fifteen-byte, 7E7E, BQ and
// area-code frames; each stored byte leaves tagged with index, class, last.
// ----------------------------------------------------------------------------
//
//  channel | signals                                          | dir
//  --------+--------------------------------------------------+-----
//  input   | in_valid, in_ready, rx_byte, abort_frame         | in
//  result  | out_valid, out_ready, frame_byte, byte_index,    | out
//          | frame_kind, last_byte                            |
//  config  | cfg_wr_en, cfg_wr_data (area code)               | in
//
//  One request per cycle while no result is stalled. A request is captured
//  in the input register, then its parser step (compares plus one
//  saturating counter add) runs combinationally into the result register,
//  whose valid flag is set when the step commits with a result.
//  Requests that produce no result (preamble, ignored bytes, abort) still
//  pass through the same slot. A stalled result only holds the input
//  register; a new request is taken in the cycle the result is drained.
//  Synchronous reset clears parser state, the area code and valid flags.
// ----------------------------------------------------------------------------
module multi_format_frame_delineator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // input channel
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic [mfd_pkg::ByteW-1:0]   rx_byte,
  input  wire logic                        abort_frame,
  // result channel
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [mfd_pkg::ByteW-1:0]   frame_byte,
  output      logic [mfd_pkg::IndexW-1:0]  byte_index,
  output      logic [mfd_pkg::KindW-1:0]   frame_kind,
  output      logic                        last_byte,
  // configuration
  input  wire logic                        cfg_wr_en,
  input  wire logic [mfd_pkg::ByteW-1:0]   cfg_wr_data
);
  import mfd_pkg::*;

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic             in_hold;     // input register occupied
  logic [ByteW-1:0] in_byte;
  logic             in_abort;
  logic             adv;         // parser step commits this cycle

  assign adv      = in_hold && (!out_valid || out_ready);
  assign in_ready = !in_hold || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_hold <= 1'b0;
    end else if (in_ready) begin
      in_hold <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte  <= rx_byte;
      in_abort <= abort_frame;
    end
  end

  // --------------------------------------------------------------------------
  // Area code register
  // --------------------------------------------------------------------------
  logic [ByteW-1:0] area_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_code <= '0;
    end else if (cfg_wr_en) begin
      area_code <= cfg_wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Parser state
  // --------------------------------------------------------------------------
  mode_t             mode, mode_next;
  logic [PreW-1:0]   pre_count, pre_count_next;
  logic [IndexW-1:0] byte_count, byte_count_next;
  logic [IndexW-1:0] target_length, target_length_next;
  logic [ByteW-1:0]  header_low, header_low_next;
  logic [ByteW-1:0]  header_high, header_high_next;

  // Index handed out for this byte; a frame start counts from zero.
  logic              count_clear;
  logic [IndexW-1:0] idx_cur;
  logic [IndexW-1:0] idx_inc;    // saturating count after taking idx_cur

  assign count_clear = (mode == MODE_IDLE) || (mode == MODE_PRE);
  assign idx_cur     = count_clear ? '0 : byte_count;
  assign idx_inc     = (idx_cur == CountMax) ? idx_cur : idx_cur + 17'd1;

  // Result of this step
  logic              res_valid;
  logic [KindW-1:0]  res_kind;
  logic              res_last;

  always_comb begin
    mode_next          = mode;
    pre_count_next     = pre_count;
    byte_count_next    = byte_count;
    target_length_next = target_length;
    header_low_next    = header_low;
    header_high_next   = header_high;
    res_valid          = 1'b0;
    res_kind           = KindStart;
    res_last           = 1'b0;

    if (in_abort) begin
      mode_next = MODE_IDLE;
    end else begin
      unique case (mode)
        MODE_IDLE: begin
          // 7E wins over preamble, preamble over area code
          priority if (in_byte == ByteFlag) begin
            mode_next       = MODE_START;
            byte_count_next = idx_inc;
            res_valid       = 1'b1;
          end else if (in_byte == BytePreamble) begin
            mode_next      = MODE_PRE;
            pre_count_next = '0;
          end else if (in_byte == area_code) begin
            mode_next       = MODE_AREA;
            byte_count_next = idx_inc;
            res_valid       = 1'b1;
            res_kind        = KindArea;
          end else begin
            mode_next = MODE_IDLE;
          end
        end
        MODE_START: begin
          byte_count_next = idx_inc;
          res_valid       = 1'b1;
          priority if (in_byte == ByteFlag && idx_cur == IdxSecond) begin
            mode_next = MODE_DUAL;
            res_kind  = KindDual;
          end else if (idx_cur == IdxLenByte) begin
            if (in_byte == ByteFifteen) begin
              mode_next          = MODE_FIFTEEN;
              target_length_next = LenFifteen;
              res_kind           = KindFifteen;
            end else begin
              mode_next          = MODE_LEN;
              target_length_next = {9'd0, in_byte} + LenShortAdd;
              res_kind           = KindLength;
              // zero length byte ends the frame here
              res_last           = (idx_inc == ({9'd0, in_byte} + LenShortAdd));
            end
          end else begin
            res_kind = KindStart;
          end
        end
        MODE_LEN, MODE_FIFTEEN: begin
          byte_count_next = idx_inc;
          res_valid       = 1'b1;
          res_kind        = (mode == MODE_LEN) ? KindLength : KindFifteen;
          res_last        = (idx_inc == target_length);
        end
        MODE_DUAL: begin
          byte_count_next = idx_inc;
          res_valid       = 1'b1;
          res_kind        = KindDual;
          if (idx_cur == IdxDualHigh) begin
            header_high_next = in_byte;
          end
          if (idx_cur == IdxDualLow) begin
            header_low_next    = in_byte;
            target_length_next = {5'd0, header_high[3:0] & DualHighMask, in_byte}
                                 + LenHdrAdd;
          end
          res_last = (idx_cur >= IdxDualLow) && (idx_inc == target_length_next);
        end
        MODE_PRE: begin
          if (in_byte == BytePreamble) begin
            if (pre_count >= PreRunFull) begin
              mode_next       = MODE_BQ;
              byte_count_next = '0;
            end else begin
              pre_count_next = pre_count + 3'd1;
            end
          end else if (pre_count >= PreRunMin) begin
            // first header byte, stored as index 0
            mode_next       = MODE_BQ;
            byte_count_next = idx_inc;
            res_valid       = 1'b1;
            res_kind        = KindBq;
          end else begin
            mode_next = MODE_PRE;
          end
        end
        MODE_BQ: begin
          byte_count_next = idx_inc;
          res_valid       = 1'b1;
          res_kind        = KindBq;
          if (idx_cur == IdxBqLow) begin
            header_low_next = in_byte;
          end
          if (idx_cur == IdxBqHigh) begin
            header_high_next   = in_byte;
            target_length_next = {1'b0, in_byte, header_low} + LenHdrAdd;
          end
          res_last = (idx_cur >= IdxBqHigh) && (idx_inc == target_length_next);
        end
        MODE_AREA: begin
          byte_count_next = idx_inc;
          res_valid       = 1'b1;
          res_kind        = KindArea;
          res_last        = (idx_cur >= IdxAreaLast);
        end
        default: begin
          mode_next = MODE_IDLE;
        end
      endcase

      if (res_valid && res_last) begin
        mode_next = MODE_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      pre_count     <= '0;
      byte_count    <= '0;
      target_length <= '0;
      header_low    <= '0;
      header_high   <= '0;
    end else if (adv) begin
      mode          <= mode_next;
      pre_count     <= pre_count_next;
      byte_count    <= byte_count_next;
      target_length <= target_length_next;
      header_low    <= header_low_next;
      header_high   <= header_high_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res_valid && !in_abort;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      frame_byte <= in_byte;
      byte_index <= idx_cur;
      frame_kind <= res_kind;
      last_byte  <= res_last;
    end
  end

`ifndef SYNTH
  // Closing byte of a frame always returns the parser to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (adv && !in_abort && res_valid && res_last) |=> (mode == MODE_IDLE))
    else $error("parser not idle after last byte");

  // Area frames close at index 7, fifteen-byte frames at index 14.
  a_area_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_byte && frame_kind == KindArea) |-> (byte_index == IdxAreaLast))
    else $error("area frame closed at wrong index");

  a_fifteen_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_byte && frame_kind == KindFifteen)
      |-> (byte_index == LenFifteen - 17'd1))
    else $error("fifteen-byte frame closed at wrong index");

  // Back pressure only while a request sits in the input register.
  a_ready_hold: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (in_hold && out_valid && !out_ready))
    else $error("input stalled without a blocked result");
`endif

endmodule : multi_format_frame_delineator
`default_nettype wire

// ----- tb/tb_multi_format_frame_delineator.sv -----
// ----------------------------------------------------------------------------
// tb_multi_format_frame_delineator
// Self-checking bench for the frame delineator: a directed table of requests,
// then random frame traffic under several area codes. Every result is checked
// field by field against a parser model in the bench or a row's expectation.
// ----------------------------------------------------------------------------
module tb_multi_format_frame_delineator;
  timeunit 1ns;
  timeprecision 1ps;

  import mfd_pkg::*;

  // One result item as the block emits it
  typedef struct packed {
    logic [ByteW-1:0]  data;
    logic [IndexW-1:0] idx;
    logic [KindW-1:0]  kind;
    logic              last;
  } frame_res_t;

  // How a directed row is checked
  typedef enum logic [1:0] {
    CHK_MODEL,   // expectation from the parser model
    CHK_TYPED,   // expectation written in the row
    CHK_NONE     // row must produce no result
  } row_check_t;

  typedef struct packed {
    logic [ByteW-1:0] rx;
    logic             ab;
    row_check_t       chk;
    frame_res_t       res;
  } stim_row_t;

  localparam frame_res_t NO_RES = '0;
  localparam int unsigned DIR_ROWS = 27;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_RESULTS = 110;

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic [ByteW-1:0]  rx_byte = '0;
  logic              abort_frame = 1'b0;
  logic              out_ready = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [ByteW-1:0]  cfg_wr_data = '0;

  logic              in_ready;
  logic              out_valid;
  logic [ByteW-1:0]  frame_byte;
  logic [IndexW-1:0] byte_index;
  logic [KindW-1:0]  frame_kind;
  logic              last_byte;

  always #2 clk = ~clk;

  multi_format_frame_delineator uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .abort_frame (abort_frame),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_byte  (frame_byte),
    .byte_index  (byte_index),
    .frame_kind  (frame_kind),
    .last_byte   (last_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  frame_res_t  pending_frames[$];   // results still owed by the block
  logic [8:0]  burst_q[$];          // {abort, byte} requests of one sequence
  stim_row_t   dir_tab [DIR_ROWS];

  int err_count   = 0;
  int checked     = 0;
  int req_count   = 0;
  int made_count  = 0;
  int cfg_writes  = 0;
  int kind_done [6];

  int  gap_pct     = 12;     // sender: chance of an idle burst after a request
  bit  quiet       = 1'b0;   // last part: no idling on either side
  bit  hold_req    = 1'b0;   // asks the receiver for one long hold-off
  bit  hold_active = 1'b0;

  // --------------------------------------------------------------------------
  // Parser model: own copy of the state and the area code register
  // --------------------------------------------------------------------------
  mode_t             parse_st = MODE_IDLE;
  logic [PreW-1:0]   pre_cnt  = '0;
  logic [IndexW-1:0] cnt      = '0;
  logic [IndexW-1:0] tgt      = '0;
  logic [ByteW-1:0]  hdr_lo   = '0;
  logic [ByteW-1:0]  hdr_hi   = '0;
  logic [ByteW-1:0]  area_reg = '0;

  // Position of the byte being stored; the counter stops at its maximum
  function automatic logic [IndexW-1:0] next_index();
    logic [IndexW-1:0] cur;
    cur = cnt;
    if (cnt != CountMax) cnt = cnt + 1'b1;
    return cur;
  endfunction

  task automatic delineate(input logic [ByteW-1:0] b, input logic ab,
                           output bit produced, output frame_res_t res);
    logic [IndexW-1:0] idx;
    logic [KindW-1:0]  kind;
    bit fin, emit, bq_go;
    produced = 1'b0;
    res = NO_RES;
    idx = '0;
    kind = KindStart;
    fin = 1'b0;
    emit = 1'b0;
    bq_go = 1'b0;
    // timeout: mode back to idle, everything else is kept
    if (ab) begin
      parse_st = MODE_IDLE;
      return;
    end
    case (parse_st)
      MODE_IDLE: begin
        // start precedence: flag byte, then preamble, then area code
        if (b == ByteFlag) begin
          cnt = '0;
          parse_st = MODE_START;
          idx = next_index();
          kind = KindStart;
          emit = 1'b1;
        end else if (b == BytePreamble) begin
          parse_st = MODE_PRE;
          pre_cnt = '0;
        end else if (b == area_reg) begin
          cnt = '0;
          parse_st = MODE_AREA;
          idx = next_index();
          kind = KindArea;
          emit = 1'b1;
        end
      end
      MODE_START: begin
        idx = next_index();
        emit = 1'b1;
        if (b == ByteFlag && idx == IdxSecond) begin
          parse_st = MODE_DUAL;
          kind = KindDual;
        end else if (idx == IdxLenByte) begin
          if (b == ByteFifteen) begin
            parse_st = MODE_FIFTEEN;
            tgt = LenFifteen;
            kind = KindFifteen;
          end else begin
            // a zero length byte closes the frame right here
            parse_st = MODE_LEN;
            tgt = IndexW'(b) + LenShortAdd;
            kind = KindLength;
            fin = (cnt == tgt);
          end
        end else begin
          kind = KindStart;
        end
      end
      MODE_LEN, MODE_FIFTEEN: begin
        idx = next_index();
        emit = 1'b1;
        kind = (parse_st == MODE_LEN) ? KindLength : KindFifteen;
        fin = (cnt == tgt);
      end
      MODE_DUAL: begin
        idx = next_index();
        emit = 1'b1;
        kind = KindDual;
        if (idx == IdxDualHigh) hdr_hi = b;
        if (idx == IdxDualLow) begin
          hdr_lo = b;
          tgt = IndexW'({hdr_hi[3:0] & DualHighMask, hdr_lo}) + LenHdrAdd;
        end
        fin = (idx >= IdxDualLow) && (cnt == tgt);
      end
      MODE_PRE: begin
        if (b == BytePreamble) begin
          // eighth preamble byte enters the header without being stored
          if (pre_cnt >= PreRunFull) begin
            parse_st = MODE_BQ;
            cnt = '0;
          end else begin
            pre_cnt = pre_cnt + 1'b1;
          end
        end else if (pre_cnt >= PreRunMin) begin
          // after six or seven preamble bytes this byte is header index 0
          parse_st = MODE_BQ;
          cnt = '0;
          bq_go = 1'b1;
        end
      end
      MODE_BQ: bq_go = 1'b1;
      MODE_AREA: begin
        idx = next_index();
        emit = 1'b1;
        kind = KindArea;
        fin = (idx >= IdxAreaLast);
      end
      default: parse_st = MODE_IDLE;
    endcase
    if (bq_go) begin
      idx = next_index();
      if (idx == IdxBqLow) hdr_lo = b;
      if (idx == IdxBqHigh) begin
        hdr_hi = b;
        tgt = IndexW'({hdr_hi, hdr_lo}) + LenHdrAdd;
      end
      kind = KindBq;
      fin = (idx >= IdxBqHigh) && (cnt == tgt);
      emit = 1'b1;
    end
    if (emit) begin
      produced = 1'b1;
      res = '{b, idx, kind, fin};
      if (fin) parse_st = MODE_IDLE;
    end
  endtask

  // --------------------------------------------------------------------------
  // Request side. Called at a falling edge; returns at a falling edge with
  // in_valid low. The model steps at the edge the request is taken.
  // --------------------------------------------------------------------------
  task automatic send_req(input logic [ByteW-1:0] b, input logic ab,
                          input row_check_t chk, input frame_res_t typed);
    bit got;
    frame_res_t r;
    in_valid = 1'b1;
    rx_byte = b;
    abort_frame = ab;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    delineate(b, ab, got, r);
    req_count++;
    if (got) made_count++;
    if (chk == CHK_TYPED) pending_frames.push_back(typed);
    else if (chk == CHK_MODEL && got) pending_frames.push_back(r);
    @(negedge clk);
    in_valid = 1'b0;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
      repeat ($urandom_range(1, 16)) @(negedge clk);
  endtask

  task automatic send_burst();
    foreach (burst_q[i]) send_req(burst_q[i][7:0], burst_q[i][8], CHK_MODEL, NO_RES);
  endtask

  // Register write only with nothing in flight; aborts and preamble bytes
  // leave no result, so allow for the pipeline after the queue drains.
  task automatic write_area(input logic [ByteW-1:0] v);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    area_reg = v;
    cfg_writes++;
  endtask

  // --------------------------------------------------------------------------
  // Sequence builders
  // --------------------------------------------------------------------------
  function automatic logic [ByteW-1:0] rand_byte();
    return ByteW'($urandom_range(0, 255));
  endfunction

  function automatic void push_byte(input logic [ByteW-1:0] b);
    burst_q.push_back({1'b0, b});
  endfunction

  function automatic void push_abort();
    burst_q.push_back({1'b1, rand_byte()});
  endfunction

  // 7E frame: length from byte 4, or fifteen bytes when byte 4 is 0x0A
  function automatic void build_len(input bit maxlen);
    logic [ByteW-1:0] b1, lb;
    int total;
    push_byte(ByteFlag);
    b1 = rand_byte();
    if (b1 == ByteFlag) b1 = 8'h7F;
    push_byte(b1);
    push_byte(rand_byte());
    push_byte(rand_byte());
    if (maxlen) lb = 8'hFF;
    else case ($urandom_range(0, 5))
      0: lb = ByteFifteen;
      1: lb = rand_byte();
      default: lb = ByteW'($urandom_range(0, 20));
    endcase
    push_byte(lb);
    total = (lb == ByteFifteen) ? 15 : int'(lb) + 5;
    for (int i = 5; i < total; i++) push_byte(rand_byte());
  endfunction

  // 7E7E frame: 12-bit length in bytes 11 (low nibble) and 12
  function automatic void build_dual(input bit maxlen);
    logic [11:0] lenf;
    push_byte(ByteFlag);
    push_byte(ByteFlag);
    for (int i = 2; i <= 10; i++) push_byte(rand_byte());
    if (maxlen) lenf = 12'hFFF;
    else if ($urandom_range(0, 7) == 0) lenf = 12'($urandom_range(0, 511));
    else lenf = 12'($urandom_range(0, 24));
    push_byte({4'($urandom_range(0, 15)), lenf[11:8]});
    push_byte(lenf[7:0]);
    for (int i = 13; i < int'(lenf) + 17; i++) push_byte(rand_byte());
  endfunction

  // BQ frame: six to eight preamble bytes, header, little-endian length
  function automatic void build_bq(input bit maxlen);
    int pre;
    logic [ByteW-1:0] b;
    logic [15:0] lenf;
    pre = $urandom_range(6, 8);
    push_byte(BytePreamble);
    // a stray byte early in the preamble is dropped by the block
    if ($urandom_range(0, 3) == 0) begin
      b = rand_byte();
      if (b == BytePreamble) b = 8'h5A;
      push_byte(b);
    end
    for (int i = 1; i < pre; i++) push_byte(BytePreamble);
    b = rand_byte();
    if (pre < 8 && b == BytePreamble) b = 8'h5A;
    push_byte(b);
    for (int i = 1; i <= 11; i++) push_byte(rand_byte());
    if (maxlen) lenf = 16'hFFFF;
    else if ($urandom_range(0, 7) == 0) lenf = 16'($urandom_range(0, 300));
    else lenf = 16'($urandom_range(0, 24));
    push_byte(lenf[7:0]);
    push_byte(lenf[15:8]);
    for (int i = 14; i < int'(lenf) + 17; i++) push_byte(rand_byte());
  endfunction

  function automatic void build_area();
    push_byte(area_reg);
    repeat (7) push_byte(rand_byte());
  endfunction

  function automatic bit area_usable();
    return area_reg != ByteFlag && area_reg != BytePreamble;
  endfunction

  // One random sequence: mostly well-formed frames, some broken or noise
  function automatic void build_random();
    int pick, keep;
    burst_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 22) build_len(1'b0);
    else if (pick < 40) build_dual(1'b0);
    else if (pick < 62) build_bq(1'b0);
    else if (pick < 77) begin
      if (area_usable()) build_area();
      else build_len(1'b0);
    end else if (pick < 88) begin
      // frame cut short, then the timeout
      case ($urandom_range(0, 2))
        0: build_len(1'b0);
        1: build_dual(1'b0);
        default: build_bq(1'b0);
      endcase
      keep = $urandom_range(1, burst_q.size() - 1);
      burst_q = burst_q[0:keep-1];
      push_abort();
    end else begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 3) == 0) push_abort();
        else push_byte(rand_byte());
      end
      if ($urandom_range(0, 3) != 0) push_abort();
    end
  endfunction

  task automatic run_random(input int results_wanted);
    int start;
    start = made_count;
    while (made_count - start < results_wanted) begin
      build_random();
      // some sequences go without sender gaps
      gap_pct = quiet ? 0 : (($urandom_range(0, 3) == 0) ? 0 : 12);
      send_burst();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall bursts and ready runs, one long hold-off
  // --------------------------------------------------------------------------
  initial begin
    int stall_left, run_left;
    stall_left = 0;
    run_left = 0;
    forever begin
      @(negedge clk);
      if (hold_active) begin
        out_ready = 1'b0;
      end else if (quiet) begin
        out_ready = 1'b1;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        out_ready = 1'b1;
        run_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        out_ready = 1'b0;
        stall_left = $urandom_range(1, 16) - 1;
      end else begin
        out_ready = 1'b1;
        run_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
      end
    end
  end

  // Long hold-off, counted here while the sender keeps offering requests
  initial begin
    wait (hold_req);
    @(negedge clk);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_active = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Checker
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
    err_count++;
    if (err_count <= 40)
      $display("MISMATCH %s: got %0h, want %0h (result %0d)", what, got_v, want_v,
               checked);
  endtask

  always @(posedge clk) begin : check_blk
    frame_res_t seen, want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      seen = '{frame_byte, byte_index, frame_kind, last_byte};
      if (pending_frames.size() == 0) begin
        report_mismatch("unexpected result", 32'(seen), 32'd0);
      end else begin
        want = pending_frames.pop_front();
        if (seen.data !== want.data)
          report_mismatch("frame_byte", 32'(seen.data), 32'(want.data));
        if (seen.idx !== want.idx)
          report_mismatch("byte_index", 32'(seen.idx), 32'(want.idx));
        if (seen.kind !== want.kind)
          report_mismatch("frame_kind", 32'(seen.kind), 32'(want.kind));
        if (seen.last !== want.last)
          report_mismatch("last_byte", 32'(seen.last), 32'(want.last));
        if (want.last && want.kind <= KindArea) kind_done[want.kind]++;
      end
      checked++;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    foreach (kind_done[k]) kind_done[k] = 0;

    // area code is 0 after reset, so byte 0x00 starts an area frame here
    dir_tab = '{
      '{8'h7E, 1'b1, CHK_NONE,  NO_RES},                             // abort in idle
      '{8'h20, 1'b0, CHK_NONE,  NO_RES},                             // menu key ignored
      '{8'h7E, 1'b0, CHK_TYPED, '{8'h7E, 17'd0, KindStart, 1'b0}},
      '{8'h00, 1'b0, CHK_MODEL, NO_RES},
      '{8'hFF, 1'b0, CHK_MODEL, NO_RES},
      '{8'h7E, 1'b0, CHK_MODEL, NO_RES},                             // flag past index 1
      '{8'h00, 1'b0, CHK_TYPED, '{8'h00, 17'd4, KindLength, 1'b1}},  // zero length byte
      '{8'h7E, 1'b0, CHK_TYPED, '{8'h7E, 17'd0, KindStart, 1'b0}},
      '{8'h7E, 1'b0, CHK_TYPED, '{8'h7E, 17'd1, KindDual, 1'b0}},
      '{8'h00, 1'b1, CHK_NONE,  NO_RES},                             // timeout mid frame
      '{8'hA5, 1'b0, CHK_NONE,  NO_RES},
      '{8'hA5, 1'b0, CHK_NONE,  NO_RES},
      '{8'h33, 1'b0, CHK_NONE,  NO_RES},                             // short run, dropped
      '{8'hA5, 1'b0, CHK_NONE,  NO_RES},
      '{8'hA5, 1'b0, CHK_NONE,  NO_RES},
      '{8'hA5, 1'b0, CHK_NONE,  NO_RES},
      '{8'hA5, 1'b0, CHK_NONE,  NO_RES},
      '{8'h11, 1'b0, CHK_TYPED, '{8'h11, 17'd0, KindBq, 1'b0}},      // after six preamble
      '{8'h00, 1'b1, CHK_NONE,  NO_RES},
      '{8'h00, 1'b0, CHK_TYPED, '{8'h00, 17'd0, KindArea, 1'b0}},
      '{8'hFF, 1'b0, CHK_MODEL, NO_RES},
      '{8'h55, 1'b0, CHK_MODEL, NO_RES},
      '{8'hAA, 1'b0, CHK_MODEL, NO_RES},
      '{8'h7E, 1'b0, CHK_MODEL, NO_RES},
      '{8'hA5, 1'b0, CHK_MODEL, NO_RES},
      '{8'h01, 1'b0, CHK_MODEL, NO_RES},
      '{8'h80, 1'b0, CHK_TYPED, '{8'h80, 17'd7, KindArea, 1'b1}}
    };

    // synchronous reset, released on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_tab[i])
      send_req(dir_tab[i].rx, dir_tab[i].ab, dir_tab[i].chk, dir_tab[i].res);

    // area code at its top value; this phase also carries the long hold-off
    write_area(8'hFF);
    hold_req = 1'b1;
    run_random(PHASE_RESULTS);

    // area codes shadowed by the flag and preamble starts
    write_area(ByteFlag);
    run_random(PHASE_RESULTS);
    write_area(BytePreamble);
    run_random(PHASE_RESULTS);

    // some ordinary area code
    begin
      logic [ByteW-1:0] code;
      code = ByteW'($urandom_range(1, 254));
      if (code == ByteFlag || code == BytePreamble) code = 8'h3C;
      write_area(code);
    end
    run_random(PHASE_RESULTS);

    // last part without idling: the longest length frame, then a few random ones
    write_area(8'h00);
    quiet = 1'b1;
    gap_pct = 0;
    burst_q.delete();
    push_abort();
    build_len(1'b1);
    send_burst();
    repeat (4) begin
      build_random();
      send_burst();
    end

    while (pending_frames.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run: %0d requests, %0d results checked, %0d area code writes",
             req_count, checked, cfg_writes);
    $display("Frames closed: length %0d, fifteen %0d, 7E7E %0d, BQ %0d, area %0d",
             kind_done[KindLength], kind_done[KindFifteen], kind_done[KindDual],
             kind_done[KindBq], kind_done[KindArea]);
    if (err_count == 0 && pending_frames.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/mfd_pkg.sv
sv/multi_format_frame_delineator.sv
tb/tb_multi_format_frame_delineator.sv
